@@ rtl/core/tor_pkg.sv @@
// Shared types and constants for the telnet option refuser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tor_pkg;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_POLL = 2'd1;
  localparam logic [1:0] OP_DISC = 2'd2;
  localparam logic [1:0] OP_OPEN = 2'd3;

  // Destination codes carried in the output tuser.
  localparam logic [1:0] DST_CONSOLE = 2'd0;
  localparam logic [1:0] DST_NET     = 2'd1;
  localparam logic [1:0] DST_CLOSE   = 2'd2;

  // Telnet protocol bytes.
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_CR   = 8'h0d;
  localparam logic [7:0] B_NUL  = 8'h00;

  localparam int unsigned IDLE_W = 17;
  localparam logic [15:0] IDLE_LIMIT_RESET = 16'd1800;

  // All results caused by one input item; they share one destination.
  typedef struct packed {
    logic            has_result;
    logic [1:0]      last_idx;
    logic [1:0]      dest;
    logic [3:0][7:0] bytes;
  } group_t;

endpackage

@@ rtl/core/tor_parser.sv @@
// Telnet command parser and idle timer: turns one input item into a result group.
// Depends on tor_pkg.
`timescale 1ns / 1ps

module tor_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [1:0]        op_i,
  input  logic [7:0]        byte_i,
  input  logic [15:0]       idle_limit_i,
  output tor_pkg::group_t   group_o
);

  typedef enum logic [2:0] {
    M_NORMAL = 3'd0,
    M_IAC    = 3'd1,
    M_WILL   = 3'd2,
    M_WONT   = 3'd3,
    M_DO     = 3'd4,
    M_DONT   = 3'd5,
    M_CLOSED = 3'd6
  } mode_e;

  mode_e                        mode_q, mode_d;
  logic [tor_pkg::IDLE_W-1:0]   idle_q, idle_d;
  logic [tor_pkg::IDLE_W-1:0]   idle_inc;
  logic                         is_open;
  tor_pkg::group_t              grp;

  assign is_open  = (mode_q == M_NORMAL) || (mode_q == M_IAC) || (mode_q == M_WILL) ||
                    (mode_q == M_WONT) || (mode_q == M_DO) || (mode_q == M_DONT);
  assign idle_inc = idle_q + tor_pkg::IDLE_W'(1);

  always_comb begin
    mode_d = mode_q;
    idle_d = idle_q;
    grp    = '0;
    case (op_i)
      tor_pkg::OP_BYTE: begin
        unique case (mode_q)
          M_NORMAL: begin
            if (byte_i == tor_pkg::B_IAC) begin
              mode_d = M_IAC;
            end else if (byte_i != tor_pkg::B_NUL && byte_i != tor_pkg::B_CR) begin
              idle_d         = '0;
              grp.has_result = 1'b1;
              grp.dest       = tor_pkg::DST_CONSOLE;
              grp.bytes[0]   = byte_i;
            end
          end
          M_IAC: begin
            if (byte_i == tor_pkg::B_IAC) begin
              mode_d         = M_NORMAL;
              idle_d         = '0;
              grp.has_result = 1'b1;
              grp.dest       = tor_pkg::DST_CONSOLE;
              grp.bytes[0]   = tor_pkg::B_IAC;
            end else if (byte_i == tor_pkg::B_WILL) begin
              mode_d = M_WILL;
            end else if (byte_i == tor_pkg::B_WONT) begin
              mode_d = M_WONT;
            end else if (byte_i == tor_pkg::B_DO) begin
              mode_d = M_DO;
            end else if (byte_i == tor_pkg::B_DONT) begin
              mode_d = M_DONT;
            end else begin
              mode_d = M_NORMAL;
            end
          end
          M_WILL, M_WONT, M_DO, M_DONT: begin
            // Refuse the option: IAC, verb, option, then a trailing NUL.
            mode_d         = M_NORMAL;
            grp.has_result = 1'b1;
            grp.last_idx   = 2'd3;
            grp.dest       = tor_pkg::DST_NET;
            grp.bytes[0]   = tor_pkg::B_IAC;
            grp.bytes[1]   = (mode_q == M_WILL || mode_q == M_WONT) ?
                             tor_pkg::B_DONT : tor_pkg::B_WONT;
            grp.bytes[2]   = byte_i;
            grp.bytes[3]   = tor_pkg::B_NUL;
          end
          default: ;
        endcase
      end
      tor_pkg::OP_POLL: begin
        if (is_open) begin
          if (idle_inc > {1'b0, idle_limit_i}) begin
            mode_d         = M_CLOSED;
            idle_d         = '0;
            grp.has_result = 1'b1;
            grp.dest       = tor_pkg::DST_CLOSE;
          end else begin
            idle_d = idle_inc;
          end
        end
      end
      tor_pkg::OP_DISC: begin
        if (is_open) begin
          mode_d         = M_CLOSED;
          idle_d         = '0;
          grp.has_result = 1'b1;
          grp.dest       = tor_pkg::DST_CLOSE;
        end
      end
      default: begin
        mode_d = M_NORMAL;
        idle_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_NORMAL;
      idle_q <= '0;
    end else if (advance_i) begin
      mode_q <= mode_d;
      idle_q <= idle_d;
    end
  end

  assign group_o = grp;

endmodule

@@ rtl/core/tor_out_serializer.sv @@
// Result register: holds one result group and sends its items one per cycle while m_axis_tready is high.
// Depends on tor_pkg.
`timescale 1ns / 1ps

module tor_out_serializer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  tor_pkg::group_t group_i,
  output logic            ready_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,
  output logic [1:0]      m_axis_tuser,
  output logic            m_axis_tlast
);

  tor_pkg::group_t grp_q;
  logic            valid_q;
  logic [1:0]      idx_q;
  logic            take;
  logic            at_last;

  assign at_last = (idx_q == grp_q.last_idx);
  assign take    = valid_q && m_axis_tready;
  assign ready_o = !valid_q || (take && at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i && ready_o && group_i.has_result) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (take) begin
      if (at_last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o && group_i.has_result) begin
      grp_q <= group_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = grp_q.bytes[idx_q];
  assign m_axis_tuser  = grp_q.dest;
  assign m_axis_tlast  = at_last;

endmodule

@@ rtl/core/telnet_option_refuser.sv @@
// Top level of the telnet option refuser: input register, parser, result register.
// Depends on tor_pkg, tor_parser and tor_out_serializer.
`timescale 1ns / 1ps

// Channel   Direction  tdata              tuser              tlast
// s_axis    in         data_byte [7:0]    operation [1:0]    -
// m_axis    out        out_byte [7:0]     destination [1:0]  last result of an item
// cfg       in         idle_limit [15:0]  -                  -
//
// Every input transaction is registered, parsed combinationally and its results are
// loaded into the result register, so a stream of items that each cause at most one
// result runs at one item per clock while m_axis_tready is high. An option reply is
// four transactions on m_axis and holds up the next item. Back-pressure on m_axis first
// fills the result register and then the input register before s_axis_tready drops.
// Reset clears the parser to an open session in normal mode, zeroes the idle counter
// and loads the idle limit with 1800; the configuration channel is always ready.

module telnet_option_refuser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,   // [1:0] destination
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic            in_valid_q;
  logic [1:0]      in_op_q;
  logic [7:0]      in_byte_q;
  logic [15:0]     idle_limit_q;
  logic            grp_ready;
  logic            advance;
  tor_pkg::group_t group;

  // The registered item moves on once the result register can take its group.
  assign advance       = in_valid_q && grp_ready;
  assign s_axis_tready = !in_valid_q || grp_ready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      idle_limit_q <= tor_pkg::IDLE_LIMIT_RESET;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        idle_limit_q <= cfg_data_i;
      end
    end
  end

  // The item payload needs no reset; it is qualified by the valid flag.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  tor_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .op_i         (in_op_q),
    .byte_i       (in_byte_q),
    .idle_limit_i (idle_limit_q),
    .group_o      (group)
  );

  tor_out_serializer u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance),
    .group_i       (group),
    .ready_o       (grp_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
